// ===== hdl/pfsp_pkg.sv =====
// Shared types and codes for the printf conversion specification parser.
// Character codes, argument kinds, justify/sign modes and the word formats.
// No dependencies; compile before the interfaces and the top level.
package pfsp_pkg;

	localparam int WIDTH_LIMIT_DEF = 509;

	localparam logic [7:0] INVALID_CONV = 8'hFF;

	localparam logic [1:0] JUST_LEFT  = 2'd0;
	localparam logic [1:0] JUST_RIGHT = 2'd1;
	localparam logic [1:0] JUST_ZERO  = 2'd2;

	localparam logic [1:0] SIGN_MINUS = 2'd0;
	localparam logic [1:0] SIGN_PLUS  = 2'd1;
	localparam logic [1:0] SIGN_SPACE = 2'd2;

	localparam logic [3:0] KIND_NORMAL  = 4'd0;
	localparam logic [3:0] KIND_CHAR    = 4'd1;
	localparam logic [3:0] KIND_SHORT   = 4'd2;
	localparam logic [3:0] KIND_LONG    = 4'd3;
	localparam logic [3:0] KIND_LLONG   = 4'd4;
	localparam logic [3:0] KIND_WCHAR   = 4'd5;
	localparam logic [3:0] KIND_INTMAX  = 4'd6;
	localparam logic [3:0] KIND_SIZE    = 4'd7;
	localparam logic [3:0] KIND_PTRDIFF = 4'd8;
	localparam logic [3:0] KIND_LDOUBLE = 4'd9;

	localparam logic [31:0] PREC_INT   = 32'd1;
	localparam logic [31:0] PREC_FLOAT = 32'd6;
	localparam logic [31:0] PREC_HEXF  = 32'd13;
	localparam logic [31:0] PREC_PTR   = 32'd8;
	localparam logic [34:0] PREC_SAT   = 35'h0_7FFF_FFFF;

	localparam logic [7:0] CNT_MAX  = 8'hFF;
	localparam logic [1:0] STAR_MAX = 2'd3;

	localparam logic [7:0] CH_PERCENT = "%";
	localparam logic [7:0] CH_MINUS   = "-";
	localparam logic [7:0] CH_PLUS    = "+";
	localparam logic [7:0] CH_SPACE   = " ";
	localparam logic [7:0] CH_HASH    = "#";
	localparam logic [7:0] CH_STAR    = "*";
	localparam logic [7:0] CH_DOT     = ".";
	localparam logic [7:0] CH_0       = "0";
	localparam logic [7:0] CH_9       = "9";
	localparam logic [7:0] CH_LC_H    = "h";
	localparam logic [7:0] CH_LC_L    = "l";
	localparam logic [7:0] CH_UC_L    = "L";
	localparam logic [7:0] CH_LC_J    = "j";
	localparam logic [7:0] CH_LC_T    = "t";
	localparam logic [7:0] CH_LC_Z    = "z";
	localparam logic [7:0] CH_LC_D    = "d";
	localparam logic [7:0] CH_LC_I    = "i";
	localparam logic [7:0] CH_LC_O    = "o";
	localparam logic [7:0] CH_LC_U    = "u";
	localparam logic [7:0] CH_LC_X    = "x";
	localparam logic [7:0] CH_UC_X    = "X";
	localparam logic [7:0] CH_LC_F    = "f";
	localparam logic [7:0] CH_UC_F    = "F";
	localparam logic [7:0] CH_LC_A    = "a";
	localparam logic [7:0] CH_UC_A    = "A";
	localparam logic [7:0] CH_LC_G    = "g";
	localparam logic [7:0] CH_UC_G    = "G";
	localparam logic [7:0] CH_LC_E    = "e";
	localparam logic [7:0] CH_UC_E    = "E";
	localparam logic [7:0] CH_LC_P    = "p";
	localparam logic [7:0] CH_LC_C    = "c";
	localparam logic [7:0] CH_LC_S    = "s";
	localparam logic [7:0] CH_LC_N    = "n";

	typedef struct packed {
		logic [7:0]         ch;
		logic signed [31:0] star_value;
	} fmt_word_t;

	typedef struct packed {
		logic [1:0]         justify_mode;
		logic [1:0]         sign_mode;
		logic               precision_given;
		logic               alt_form;
		logic [3:0]         argument_kind;
		logic [7:0]         conversion;
		logic [8:0]         min_width;
		logic signed [31:0] precision;
		logic [7:0]         chars_used;
		logic [1:0]         arguments_used;
	} spec_word_t;

endpackage

// ===== hdl/pfsp_fmt_if.sv =====
// Format character channel: one character and its star argument per word.
// Depends on pfsp_pkg for the word type.
interface pfsp_fmt_if;
	import pfsp_pkg::*;

	logic      valid;
	logic      ready;
	fmt_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/pfsp_spec_if.sv =====
// Parsed specification channel: one decoded conversion specification per word.
// Depends on pfsp_pkg for the word type.
interface pfsp_spec_if;
	import pfsp_pkg::*;

	logic       valid;
	logic       ready;
	spec_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/printf_format_spec_parser_unit.sv =====
// Top level of the printf conversion specification parser.
// Depends on pfsp_pkg, pfsp_fmt_if and pfsp_spec_if.
//
// Channel | Direction | Word                           | Rate
// fmt     | in        | ch, star_value                 | one word per cycle when not stalled
// spec    | out       | decoded specification fields   | at most one per fmt word
//
// Each word is taken into an input register, decoded combinationally against the
// parse state and, when it ends a specification, written to the result register.
// spec valid rises once the ending fmt word has passed the input and result registers;
// sustained rate is one word per cycle while the result is not stalled, set by the
// state update with its multiply-by-ten.
// arst_n clears the parse state and the valid flags of the input and result registers.
// A stalled result blocks the decode stage; the input register still takes one more word if it is empty.
module printf_format_spec_parser_unit #(
	parameter int WIDTH_LIMIT = pfsp_pkg::WIDTH_LIMIT_DEF
) (
	input logic              clk,
	input logic              arst_n,
	pfsp_fmt_if.sink         fmt,
	pfsp_spec_if.source      spec
);
	import pfsp_pkg::*;

	localparam int WW = $clog2(WIDTH_LIMIT + 2);
	localparam int EW = (WW > 9) ? WW : 9;
	localparam logic [31:0] WLIM = 32'(WIDTH_LIMIT);
	localparam logic [31:0] WSAT = 32'(WIDTH_LIMIT + 1);

	typedef enum logic [2:0] {
		PH_START, PH_FLAGS, PH_WDIG, PH_POSTW, PH_PREC, PH_PDIG, PH_LEN, PH_MOD
	} phase_t;

	phase_t             phase_q, n_phase;
	logic [1:0]         just_q, n_just;
	logic [1:0]         sign_q, n_sign;
	logic               pg_q, n_pg;
	logic               alt_q, n_alt;
	logic [3:0]         kind_q, n_kind;
	logic [WW-1:0]      width_q, n_width;
	logic [31:0]        prec_q, n_prec;
	logic [7:0]         cnt_q, n_cnt;
	logic [1:0]         star_q, n_star;

	logic               valid_s1;
	fmt_word_t          data_s1;
	logic               go_s1;

	logic               out_valid_q;
	spec_word_t         out_data_q;

	logic               emit;
	logic [7:0]         conv;
	spec_word_t         res;
	logic               go_flag, go_post, go_len, go_fin;
	logic [7:0]         c;
	logic [31:0]        star;
	logic [3:0]         dig;
	logic               is_dig;
	logic [31:0]        mag;
	logic [WW+3:0]      wprod;
	logic [34:0]        pprod;
	logic [EW-1:0]      width_ext;

	function automatic logic int_mod(input logic [3:0] k, input logic with_char);
		int_mod = (k == KIND_SHORT) || (k == KIND_INTMAX) || (k == KIND_SIZE) ||
			(k == KIND_PTRDIFF) || (k == KIND_LLONG) || (with_char && (k == KIND_CHAR));
	endfunction

	assign go_s1     = !out_valid_q || spec.ready;
	assign fmt.ready = !valid_s1 || go_s1;
	assign spec.valid = out_valid_q;
	assign spec.data  = out_data_q;

	always_comb begin
		c      = data_s1.ch;
		star   = data_s1.star_value;
		dig    = 4'(c - CH_0);
		is_dig = c inside {[CH_0:CH_9]};
		mag    = star[31] ? (~star + 32'd1) : star;
		wprod  = ((WW+4)'(width_q) << 3) + ((WW+4)'(width_q) << 1) + (WW+4)'(dig);
		pprod  = ({3'b000, prec_q} << 3) + ({3'b000, prec_q} << 1) + 35'(dig);

		n_phase = phase_q;
		n_just  = just_q;
		n_sign  = sign_q;
		n_pg    = pg_q;
		n_alt   = alt_q;
		n_kind  = kind_q;
		n_width = width_q;
		n_prec  = prec_q;
		n_cnt   = (cnt_q == CNT_MAX) ? CNT_MAX : cnt_q + 8'd1;
		n_star  = star_q;
		emit    = 1'b0;
		conv    = INVALID_CONV;
		go_flag = 1'b0;
		go_post = 1'b0;
		go_len  = 1'b0;
		go_fin  = 1'b0;

		case (phase_q)
			PH_START: begin
				if (c == CH_PERCENT) begin
					emit = 1'b1;
					conv = CH_PERCENT;
				end else begin
					go_flag = 1'b1;
				end
			end
			PH_FLAGS: go_flag = 1'b1;
			PH_WDIG: begin
				if (is_dig) begin
					n_width = (32'(wprod) > WSAT) ? WW'(WSAT) : WW'(wprod);
				end else begin
					go_post = 1'b1;
				end
			end
			PH_POSTW: go_post = 1'b1;
			PH_PREC: begin
				if (c == CH_STAR) begin
					n_prec  = star;
					if (star[31]) n_pg = 1'b0;
					if (star_q != STAR_MAX) n_star = star_q + 2'd1;
					n_phase = PH_LEN;
				end else if (is_dig) begin
					n_prec  = 32'(dig);
					n_phase = PH_PDIG;
				end else begin
					go_len = 1'b1;
				end
			end
			PH_PDIG: begin
				if (is_dig) begin
					n_prec = (pprod > PREC_SAT) ? PREC_SAT[31:0] : pprod[31:0];
				end else begin
					go_len = 1'b1;
				end
			end
			PH_LEN: go_len = 1'b1;
			PH_MOD: begin
				if (kind_q == KIND_SHORT && c == CH_LC_H) begin
					n_kind = KIND_CHAR;
				end else if (kind_q == KIND_LONG && c == CH_LC_L) begin
					n_kind = KIND_LLONG;
				end else begin
					go_fin = 1'b1;
				end
			end
			default: go_fin = 1'b1;
		endcase

		if (go_flag) begin
			case (c)
				CH_MINUS: begin
					n_just  = JUST_LEFT;
					n_phase = PH_FLAGS;
				end
				CH_PLUS: begin
					n_sign  = SIGN_PLUS;
					n_phase = PH_FLAGS;
				end
				CH_SPACE: begin
					if (sign_q != SIGN_PLUS) n_sign = SIGN_SPACE;
					n_phase = PH_FLAGS;
				end
				CH_HASH: begin
					n_alt   = 1'b1;
					n_phase = PH_FLAGS;
				end
				CH_0: begin
					if (just_q != JUST_LEFT) n_just = JUST_ZERO;
					n_phase = PH_FLAGS;
				end
				CH_STAR: begin
					if (star[31]) n_just = JUST_LEFT;
					n_width = (mag > WSAT) ? WW'(WSAT) : WW'(mag);
					if (star_q != STAR_MAX) n_star = star_q + 2'd1;
					n_phase = PH_POSTW;
				end
				default: begin
					if (is_dig) begin
						n_width = WW'(dig);
						n_phase = PH_WDIG;
					end else begin
						go_post = 1'b1;
					end
				end
			endcase
		end

		if (go_post) begin
			if (32'(width_q) > WLIM) begin
				emit = 1'b1;
				conv = INVALID_CONV;
			end else if (c == CH_DOT) begin
				n_pg    = 1'b1;
				n_phase = PH_PREC;
			end else begin
				go_len = 1'b1;
			end
		end

		if (go_len) begin
			case (c)
				CH_LC_H: begin n_kind = KIND_SHORT;   n_phase = PH_MOD; end
				CH_LC_L: begin n_kind = KIND_LONG;    n_phase = PH_MOD; end
				CH_UC_L: begin n_kind = KIND_LDOUBLE; n_phase = PH_MOD; end
				CH_LC_J: begin n_kind = KIND_INTMAX;  n_phase = PH_MOD; end
				CH_LC_T: begin n_kind = KIND_PTRDIFF; n_phase = PH_MOD; end
				CH_LC_Z: begin n_kind = KIND_SIZE;    n_phase = PH_MOD; end
				default: go_fin = 1'b1;
			endcase
		end

		if (go_fin) begin
			emit = 1'b1;
			conv = c;
			case (c)
				CH_LC_D, CH_LC_I, CH_LC_O, CH_LC_U, CH_LC_X, CH_UC_X: begin
					if (kind_q == KIND_LDOUBLE) conv = INVALID_CONV;
					else if (!pg_q) n_prec = PREC_INT;
					else if (just_q == JUST_ZERO) n_just = JUST_RIGHT;
				end
				CH_LC_F, CH_UC_F: begin
					if (int_mod(kind_q, 1'b0)) conv = INVALID_CONV;
					else if (!pg_q) n_prec = PREC_FLOAT;
				end
				CH_LC_A, CH_UC_A: begin
					if (!pg_q) n_prec = PREC_HEXF;
					if (int_mod(kind_q, 1'b1)) conv = INVALID_CONV;
				end
				CH_LC_G, CH_UC_G, CH_LC_E, CH_UC_E: begin
					if ((c == CH_LC_G || c == CH_UC_G) && prec_q == 32'd0) n_prec = PREC_INT;
					if (int_mod(kind_q, 1'b1)) conv = INVALID_CONV;
					else if (!pg_q) n_prec = PREC_FLOAT;
				end
				CH_LC_P: begin
					conv   = CH_LC_X;
					n_alt  = 1'b1;
					n_kind = KIND_LONG;
					n_prec = PREC_PTR;
				end
				CH_LC_C: begin
					if (kind_q == KIND_LONG) n_kind = KIND_WCHAR;
					else if (pg_q || kind_q != KIND_NORMAL) conv = INVALID_CONV;
				end
				CH_LC_S: begin
					if (kind_q == KIND_LONG) n_kind = KIND_WCHAR;
					else if (kind_q != KIND_NORMAL) conv = INVALID_CONV;
				end
				CH_LC_N: begin
					if (kind_q == KIND_LDOUBLE) conv = INVALID_CONV;
				end
				default: conv = INVALID_CONV;
			endcase
		end

		width_ext           = EW'(n_width);
		res.justify_mode    = n_just;
		res.sign_mode       = n_sign;
		res.precision_given = n_pg;
		res.alt_form        = n_alt;
		res.argument_kind   = n_kind;
		res.conversion      = conv;
		res.min_width       = width_ext[8:0];
		res.precision       = n_prec;
		res.chars_used      = n_cnt;
		res.arguments_used  = n_star;

		if (emit) begin
			n_phase = PH_START;
			n_just  = JUST_RIGHT;
			n_sign  = SIGN_MINUS;
			n_pg    = 1'b0;
			n_alt   = 1'b0;
			n_kind  = KIND_NORMAL;
			n_width = '0;
			n_prec  = '0;
			n_cnt   = '0;
			n_star  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fmt.ready) begin
			valid_s1 <= fmt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fmt.ready && fmt.valid) begin
			data_s1 <= fmt.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			just_q      <= JUST_RIGHT;
			sign_q      <= SIGN_MINUS;
			pg_q        <= 1'b0;
			alt_q       <= 1'b0;
			kind_q      <= KIND_NORMAL;
			width_q     <= '0;
			prec_q      <= '0;
			cnt_q       <= '0;
			star_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (valid_s1 && go_s1) begin
				phase_q <= n_phase;
				just_q  <= n_just;
				sign_q  <= n_sign;
				pg_q    <= n_pg;
				alt_q   <= n_alt;
				kind_q  <= n_kind;
				width_q <= n_width;
				prec_q  <= n_prec;
				cnt_q   <= n_cnt;
				star_q  <= n_star;
			end
			if (valid_s1 && go_s1 && emit) begin
				out_valid_q <= 1'b1;
			end else if (spec.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && go_s1 && emit) begin
			out_data_q <= res;
		end
	end

endmodule

// ===== dv/printf_format_spec_parser_unit_test.sv =====
`timescale 1ns / 1ps
// Testbench for printf_format_spec_parser_unit: queued format characters feed a
// driver, a clocked predictor decodes each accepted word and the monitor checks results.
// Depends on pfsp_pkg, pfsp_fmt_if, pfsp_spec_if and the top level in hdl.
module printf_format_spec_parser_unit_test;
	import pfsp_pkg::*;

	localparam int WLIM = WIDTH_LIMIT_DEF;

	typedef enum logic [2:0] {
		PS_START, PS_FLAGS, PS_WIDTH, PS_AFTER_WIDTH, PS_DOT, PS_PREC, PS_LEN, PS_MOD
	} parse_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pfsp_fmt_if  fmt();
	pfsp_spec_if spec();

	printf_format_spec_parser_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.fmt    (fmt),
		.spec   (spec)
	);

	always #1 clk = ~clk;

	fmt_word_t  chars_pending [$];
	spec_word_t specs_due [$];
	int         chars_total = 0;
	int         chars_sent = 0;
	int         mismatches = 0;
	logic       fmt_taken = 1'b0;

	logic [7:0] flag_chars [5] = '{CH_MINUS, CH_PLUS, CH_SPACE, CH_HASH, CH_0};
	logic [7:0] conv_chars [18] = '{CH_LC_D, CH_LC_I, CH_LC_O, CH_LC_U, CH_LC_X, CH_UC_X,
		CH_LC_F, CH_UC_F, CH_LC_A, CH_UC_A, CH_LC_G, CH_UC_G, CH_LC_E, CH_UC_E,
		CH_LC_P, CH_LC_C, CH_LC_S, CH_LC_N};

	parse_phase_t ps;
	logic [1:0]   st_just;
	logic [1:0]   st_sign;
	logic         st_given;
	logic         st_alt;
	logic [3:0]   st_kind;
	logic [8:0]   st_width;
	logic [31:0]  st_prec;
	logic [7:0]   st_count;
	logic [1:0]   st_stars;

	function automatic void clear_parse();
		ps = PS_START;
		st_just = JUST_RIGHT;
		st_sign = SIGN_MINUS;
		st_given = 1'b0;
		st_alt = 1'b0;
		st_kind = KIND_NORMAL;
		st_width = '0;
		st_prec = '0;
		st_count = '0;
		st_stars = '0;
	endfunction

	function automatic spec_word_t pack_spec(input logic [7:0] conv);
		spec_word_t r;
		r.justify_mode = st_just;
		r.sign_mode = st_sign;
		r.precision_given = st_given;
		r.alt_form = st_alt;
		r.argument_kind = st_kind;
		r.conversion = conv;
		r.min_width = st_width;
		r.precision = st_prec;
		r.chars_used = st_count;
		r.arguments_used = st_stars;
		clear_parse();
		return r;
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic bit int_kind(input logic [3:0] k, input bit with_char);
		return k == KIND_SHORT || k == KIND_INTMAX || k == KIND_SIZE || k == KIND_PTRDIFF ||
			k == KIND_LLONG || (with_char && k == KIND_CHAR);
	endfunction

	function automatic bit close_spec(input logic [7:0] c, output spec_word_t r);
		logic [7:0] conv;
		bit         given;
		conv = c;
		given = st_given;
		case (c)
			CH_LC_D, CH_LC_I, CH_LC_O, CH_LC_U, CH_LC_X, CH_UC_X: begin
				if (st_kind == KIND_LDOUBLE)
					conv = INVALID_CONV;
				else if (!given)
					st_prec = PREC_INT;
				else if (st_just == JUST_ZERO)
					st_just = JUST_RIGHT;
			end
			CH_LC_F, CH_UC_F: begin
				if (int_kind(st_kind, 1'b0))
					conv = INVALID_CONV;
				else if (!given)
					st_prec = PREC_FLOAT;
			end
			CH_LC_A, CH_UC_A: begin
				if (!given)
					st_prec = PREC_HEXF;
				if (int_kind(st_kind, 1'b1))
					conv = INVALID_CONV;
			end
			CH_LC_G, CH_UC_G, CH_LC_E, CH_UC_E: begin
				if ((c == CH_LC_G || c == CH_UC_G) && st_prec == '0)
					st_prec = PREC_INT;
				if (int_kind(st_kind, 1'b1))
					conv = INVALID_CONV;
				else if (!given)
					st_prec = PREC_FLOAT;
			end
			CH_LC_P: begin
				conv = CH_LC_X;
				st_alt = 1'b1;
				st_kind = KIND_LONG;
				st_prec = PREC_PTR;
			end
			CH_LC_C: begin
				if (st_kind == KIND_LONG)
					st_kind = KIND_WCHAR;
				else if (given || st_kind != KIND_NORMAL)
					conv = INVALID_CONV;
			end
			CH_LC_S: begin
				if (st_kind == KIND_LONG)
					st_kind = KIND_WCHAR;
				else if (st_kind != KIND_NORMAL)
					conv = INVALID_CONV;
			end
			CH_LC_N: begin
				if (st_kind == KIND_LDOUBLE)
					conv = INVALID_CONV;
			end
			default: conv = INVALID_CONV;
		endcase
		r = pack_spec(conv);
		return 1'b1;
	endfunction

	function automatic bit length_or_close(input logic [7:0] c, output spec_word_t r);
		logic [3:0] k;
		case (c)
			CH_LC_H: k = KIND_SHORT;
			CH_LC_L: k = KIND_LONG;
			CH_UC_L: k = KIND_LDOUBLE;
			CH_LC_J: k = KIND_INTMAX;
			CH_LC_T: k = KIND_PTRDIFF;
			CH_LC_Z: k = KIND_SIZE;
			default: return close_spec(c, r);
		endcase
		st_kind = k;
		ps = PS_MOD;
		return 1'b0;
	endfunction

	function automatic bit after_width(input logic [7:0] c, output spec_word_t r);
		if (st_width > WLIM) begin
			r = pack_spec(INVALID_CONV);
			return 1'b1;
		end
		if (c == CH_DOT) begin
			st_given = 1'b1;
			ps = PS_DOT;
			return 1'b0;
		end
		return length_or_close(c, r);
	endfunction

	function automatic bit flag_or_width(input logic [7:0] c, input logic [31:0] star,
			output spec_word_t r);
		logic [31:0] mag;
		case (c)
			CH_MINUS: begin
				st_just = JUST_LEFT;
				ps = PS_FLAGS;
				return 1'b0;
			end
			CH_PLUS: begin
				st_sign = SIGN_PLUS;
				ps = PS_FLAGS;
				return 1'b0;
			end
			CH_SPACE: begin
				if (st_sign != SIGN_PLUS)
					st_sign = SIGN_SPACE;
				ps = PS_FLAGS;
				return 1'b0;
			end
			CH_HASH: begin
				st_alt = 1'b1;
				ps = PS_FLAGS;
				return 1'b0;
			end
			CH_0: begin
				if (st_just != JUST_LEFT)
					st_just = JUST_ZERO;
				ps = PS_FLAGS;
				return 1'b0;
			end
			default: ;
		endcase
		if (c == CH_STAR) begin
			mag = star;
			if (star[31]) begin
				st_just = JUST_LEFT;
				mag = ~star + 32'd1;
			end
			if (mag > 32'(WLIM + 1))
				mag = 32'(WLIM + 1);
			st_width = mag[8:0];
			if (st_stars < STAR_MAX)
				st_stars++;
			ps = PS_AFTER_WIDTH;
			return 1'b0;
		end
		if (is_digit(c)) begin
			st_width = 9'(c - CH_0);
			ps = PS_WIDTH;
			return 1'b0;
		end
		return after_width(c, r);
	endfunction

	// Advance the parse by one accepted word; returns 1 when a specification ends.
	function automatic bit parse_char(input fmt_word_t w, output spec_word_t r);
		logic [7:0]  c;
		int          wide;
		logic [63:0] pd;
		c = w.ch;
		if (st_count < CNT_MAX)
			st_count++;
		case (ps)
			PS_START: begin
				if (c == CH_PERCENT) begin
					r = pack_spec(CH_PERCENT);
					return 1'b1;
				end
				return flag_or_width(c, w.star_value, r);
			end
			PS_FLAGS: return flag_or_width(c, w.star_value, r);
			PS_WIDTH: begin
				if (is_digit(c)) begin
					wide = int'(st_width) * 10 + int'(c) - int'(CH_0);
					if (wide > WLIM + 1)
						wide = WLIM + 1;
					st_width = wide[8:0];
					return 1'b0;
				end
				return after_width(c, r);
			end
			PS_AFTER_WIDTH: return after_width(c, r);
			PS_DOT: begin
				if (c == CH_STAR) begin
					st_prec = w.star_value;
					if (w.star_value[31])
						st_given = 1'b0;
					if (st_stars < STAR_MAX)
						st_stars++;
					ps = PS_LEN;
					return 1'b0;
				end
				if (is_digit(c)) begin
					st_prec = 32'(c - CH_0);
					ps = PS_PREC;
					return 1'b0;
				end
				return length_or_close(c, r);
			end
			PS_PREC: begin
				if (is_digit(c)) begin
					pd = 64'(st_prec);
					pd = pd * 64'd10 + 64'(c - CH_0);
					if (pd > 64'(PREC_SAT))
						pd = 64'(PREC_SAT);
					st_prec = pd[31:0];
					return 1'b0;
				end
				return length_or_close(c, r);
			end
			PS_LEN: return length_or_close(c, r);
			default: begin
				if (st_kind == KIND_SHORT && c == CH_LC_H) begin
					st_kind = KIND_CHAR;
					return 1'b0;
				end
				if (st_kind == KIND_LONG && c == CH_LC_L) begin
					st_kind = KIND_LLONG;
					return 1'b0;
				end
				return close_spec(c, r);
			end
		endcase
	endfunction

	task automatic report(input string msg);
		$display("%0t ns: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report($sformatf("spec.%s got %0h, expected %0h", name, got, want));
	endtask

	task automatic push_char(input logic [7:0] c, input logic [31:0] star);
		fmt_word_t w;
		w.ch = c;
		w.star_value = star;
		chars_pending.push_back(w);
	endtask

	function automatic logic [31:0] pick_star();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom;
			3: return 32'd0 - $urandom_range(1, 20);
			default: return $urandom_range(600);
		endcase
	endfunction

	task automatic push_digits(input int count, input bit lead_nonzero);
		for (int i = 0; i < count; i++)
			push_char(8'(CH_0 + ((i == 0 && lead_nonzero) ? $urandom_range(1, 9) :
				$urandom_range(9))), $urandom);
	endtask

	task automatic push_random_spec(input bit long_flags);
		int r;
		r = $urandom_range(99);
		if (r < 5) begin
			push_char(CH_PERCENT, $urandom);
		end else if (r < 13) begin
			repeat ($urandom_range(1, 3))
				push_char(8'($urandom_range(255)), $urandom);
		end else begin
			repeat (long_flags ? 270 : $urandom_range(0, 3))
				push_char(flag_chars[$urandom_range(4)], $urandom);
			case ($urandom_range(3))
				0: ;
				1: push_char(CH_STAR, pick_star());
				default: push_digits($urandom_range(1, 4), 1'b1);
			endcase
			case ($urandom_range(4))
				2: begin
					push_char(CH_DOT, $urandom);
					push_digits(($urandom_range(9) == 0) ? 11 : $urandom_range(0, 2), 1'b0);
				end
				3: begin
					push_char(CH_DOT, $urandom);
					push_char(CH_STAR, pick_star());
				end
				4: push_char(CH_DOT, $urandom);
				default: ;
			endcase
			case ($urandom_range(9))
				0: push_char(CH_LC_H, $urandom);
				1: begin
					push_char(CH_LC_H, $urandom);
					push_char(CH_LC_H, $urandom);
				end
				2: push_char(CH_LC_L, $urandom);
				3: begin
					push_char(CH_LC_L, $urandom);
					push_char(CH_LC_L, $urandom);
				end
				4: push_char(CH_UC_L, $urandom);
				5: push_char(CH_LC_J, $urandom);
				6: push_char(CH_LC_T, $urandom);
				7: push_char(CH_LC_Z, $urandom);
				default: ;
			endcase
			if ($urandom_range(9) == 0)
				push_char(8'($urandom_range(255)), $urandom);
			else
				push_char(conv_chars[$urandom_range(17)], $urandom);
		end
	endtask

	always @(posedge clk) begin : spec_check
		spec_word_t want;
		spec_word_t decoded;
		if (arst_n && spec.valid && spec.ready) begin
			if (specs_due.size() == 0) begin
				report($sformatf("result word with none expected, conversion %0h",
					spec.data.conversion));
			end else begin
				want = specs_due.pop_front();
				check_field("justify_mode", spec.data.justify_mode, want.justify_mode);
				check_field("sign_mode", spec.data.sign_mode, want.sign_mode);
				check_field("precision_given", spec.data.precision_given,
					want.precision_given);
				check_field("alt_form", spec.data.alt_form, want.alt_form);
				check_field("argument_kind", spec.data.argument_kind, want.argument_kind);
				check_field("conversion", spec.data.conversion, want.conversion);
				check_field("min_width", spec.data.min_width, want.min_width);
				check_field("precision", spec.data.precision, want.precision);
				check_field("chars_used", spec.data.chars_used, want.chars_used);
				check_field("arguments_used", spec.data.arguments_used, want.arguments_used);
			end
		end
		if (arst_n && fmt.valid && fmt.ready) begin
			if (parse_char(fmt.data, decoded))
				specs_due.push_back(decoded);
		end
		fmt_taken <= arst_n && fmt.valid && fmt.ready;
	end

	always @(negedge clk) begin
		int send_idle;
		int take_idle;
		if (chars_sent < chars_total / 3) begin
			send_idle = 26;
			take_idle = 68;
		end else if (chars_sent < 2 * chars_total / 3) begin
			send_idle = 68;
			take_idle = 26;
		end else begin
			send_idle = 0;
			take_idle = 0;
		end
		if (arst_n) begin
			if (!fmt.valid || fmt_taken) begin
				if (chars_pending.size() != 0 && $urandom_range(99) >= send_idle) begin
					fmt.valid <= 1'b1;
					fmt.data <= chars_pending.pop_front();
					chars_sent++;
				end else begin
					fmt.valid <= 1'b0;
				end
			end
			spec.ready <= ($urandom_range(99) >= take_idle);
		end
	end

	initial begin
		fmt.valid = 1'b0;
		fmt.data = '0;
		spec.ready = 1'b0;
		clear_parse();

		push_char(CH_PERCENT, $urandom);
		push_char(CH_STAR, 32'h8000_0000);
		push_char(CH_LC_D, $urandom);
		push_char(CH_0, $urandom);
		push_char(CH_SPACE, $urandom);
		push_char(CH_PLUS, $urandom);
		push_char(CH_STAR, 32'hFFFF_FFFD);
		push_char(CH_DOT, $urandom);
		push_char(CH_STAR, 32'hFFFF_FFFF);
		push_char(CH_UC_L, $urandom);
		push_char(CH_LC_G, $urandom);
		push_char(CH_HASH, $urandom);
		push_char(8'(CH_0 + 8'd5), $urandom);
		push_char(8'(CH_0 + 8'd1), $urandom);
		push_char(CH_0, $urandom);
		push_char(CH_LC_X, $urandom);
		push_char(CH_LC_P, $urandom);
		push_char(CH_LC_H, $urandom);
		push_char(CH_LC_H, $urandom);
		push_char(8'hC8, $urandom);
		push_char(CH_LC_L, $urandom);
		push_char(CH_LC_L, $urandom);
		push_char(CH_LC_S, $urandom);
		push_char(CH_LC_Z, $urandom);
		push_char(CH_LC_C, $urandom);

		for (int n = 0; chars_pending.size() < 900; n++)
			push_random_spec(n == 40);
		chars_total = chars_pending.size();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (chars_pending.size() != 0 || fmt.valid)
			@(posedge clk);
		while (specs_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (mismatches == 0 && specs_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#400_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
